[rtl/omrq_pkg.sv]
// Shared types and constants for the ordered match-and-remove queue.
`default_nettype none
package omrq_pkg;

   localparam int unsigned OccW = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TAKE   = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic        event_kind;
      logic [31:0] event_time;
      logic [31:0] window_number;
      logic [8:0]  scan_code;
      logic [30:0] key_symbol;
   } record_type;

   typedef struct packed {
      logic active;
      logic capture;
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

[rtl/omrq_req_if.sv]
// Request channel: valid/ready handshake with one key event record and an opcode.
`default_nettype none
interface omrq_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        event_kind;
   logic [31:0] event_time;
   logic [31:0] window_number;
   logic [8:0]  scan_code;
   logic [30:0] key_symbol;

   modport source (output valid, output op, output event_kind, output event_time,
                   output window_number, output scan_code, output key_symbol,
                   input ready);
   modport sink   (input valid, input op, input event_kind, input event_time,
                   input window_number, input scan_code, input key_symbol,
                   output ready);
endinterface
`default_nettype wire

[rtl/omrq_rsp_if.sv]
// Response channel: valid/ready handshake with match, drop and occupancy status.
`default_nettype none
interface omrq_rsp_if;
   logic       valid;
   logic       ready;
   logic       matched;
   logic       dropped_oldest;
   logic [6:0] occupancy;

   modport source (output valid, output matched, output dropped_oldest,
                   output occupancy, input ready);
   modport sink   (input valid, input matched, input dropped_oldest,
                   input occupancy, output ready);
endinterface
`default_nettype wire

[rtl/ordered_match_remove_queue.sv]
// Ordered match-and-remove queue of key event records built from a chain of slot cells.
// A request is accepted only in idle; its compare is captured in the accept cycle and
// the shift and response follow in the execute state, which waits on a stalled response.
// A full queue drops its oldest record on insert; the cells shift down one slot in parallel.
// Synchronous reset clears the fill count, state and response valid; record storage is
// left uninitialized and is only read below the fill count.
`default_nettype none
module ordered_match_remove_queue #(
   parameter int unsigned DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   omrq_req_if.sink    req_chan,
   omrq_rsp_if.source  rsp_chan
);
   import omrq_pkg::*;

   localparam int unsigned CountW = $clog2(DEPTH + 1);

   state_type            state_ff, state_in;
   logic [CountW-1:0]    count_ff, count_in;
   op_type               op_ff;
   record_type           req_rec_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic                 rsp_dropped_ff, rsp_dropped_in;
   logic [OccW-1:0]      rsp_occ_ff, rsp_occ_in;

   record_type           key;
   record_type           cell_rec [DEPTH];
   cell_ctrl_type        cell_ctrl [DEPTH];
   logic [DEPTH-1:0]     hit;
   logic [DEPTH-1:0]     load_vec;
   logic                 accept;
   logic                 exec_fire;
   logic                 full;
   logic                 any_hit;
   logic                 is_take;

   assign key.event_kind    = req_chan.event_kind;
   assign key.event_time    = req_chan.event_time;
   assign key.window_number = req_chan.window_number;
   assign key.scan_code     = req_chan.scan_code;
   assign key.key_symbol    = req_chan.key_symbol;

   assign accept  = req_chan.valid && req_chan.ready;
   assign full    = (count_ff == CountW'(DEPTH));
   assign any_hit = |hit;
   assign is_take = (op_ff == OP_TAKE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      exec_fire      = 1'b0;
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_EXEC: exec_fire = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            req_chan.ready = 1'b0;
            exec_fire      = 1'b0;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_ctrl[i].active  = (CountW'(i) < count_ff);
      assign cell_ctrl[i].capture = accept && (req_chan.op == OP_TAKE);
      assign cell_ctrl[i].shift   = exec_fire &&
                                    ((!is_take && full) || (is_take && (|hit[i:0])));
      assign cell_ctrl[i].load    = load_vec[i];
      assign load_vec[i]          = exec_fire && !is_take &&
                                    (full ? (i == DEPTH - 1) : (count_ff == CountW'(i)));

      omrq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[i]),
         .key      (key),
         .new_rec  (req_rec_ff),
         .next_rec ((i == DEPTH - 1) ? req_rec_ff : cell_rec[(i + 1) % DEPTH]),
         .rec      (cell_rec[i]),
         .hit      (hit[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_occ_in     = rsp_occ_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec_fire) begin
         if (!is_take && !full) begin
            count_in = count_ff + CountW'(1);
         end else if (is_take && any_hit) begin
            count_in = count_ff - CountW'(1);
         end
         rsp_valid_in   = 1'b1;
         rsp_matched_in = is_take && any_hit;
         rsp_dropped_in = !is_take && full;
         rsp_occ_in     = OccW'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_chan.op);
         req_rec_ff <= key;
      end
      rsp_matched_ff <= rsp_matched_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.matched        = rsp_matched_ff;
   assign rsp_chan.dropped_oldest = rsp_dropped_ff;
   assign rsp_chan.occupancy      = rsp_occ_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(DEPTH))
      else $error("fill count above depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter execute");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec))
      else $error("more than one cell loaded on insert");

   a_take_count: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && is_take && any_hit) |=> (count_ff == $past(count_ff) - CountW'(1)))
      else $error("count not decremented on matched take");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_matched_ff && rsp_dropped_ff))
      else $error("response reports both match and drop");
`endif

endmodule
`default_nettype wire

[rtl/omrq_cell.sv]
// One queue slot: holds a record, compares it against the search key, shifts from its neighbor.
`default_nettype none
module omrq_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  omrq_pkg::cell_ctrl_type     ctrl,
   input  omrq_pkg::record_type        key,
   input  omrq_pkg::record_type        new_rec,
   input  omrq_pkg::record_type        next_rec,
   output omrq_pkg::record_type        rec,
   output logic                        hit
);
   import omrq_pkg::*;

   record_type rec_ff, rec_in;
   logic       hit_ff, hit_in;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.load) begin
         rec_in = new_rec;
      end else if (ctrl.shift) begin
         rec_in = next_rec;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = ctrl.active && (rec_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign rec = rec_ff;
   assign hit = hit_ff;

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the ordered match-and-remove queue of key event records.
`timescale 1ns / 1ps
module tb_top;
   import omrq_pkg::*;

   localparam int unsigned DEPTH        = 64;
   localparam int unsigned RANDOM_ITEMS = 1140;
   localparam int unsigned SEGMENT_LEN  = 96;
   localparam int unsigned HOLD_CYCLES  = 160;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   typedef enum int {
      MODE_FILL  = 0,
      MODE_DRAIN = 1,
      MODE_MIXED = 2
   } traffic_mode_type;

   typedef struct packed {
      logic       matched;
      logic       dropped_oldest;
      logic [6:0] occupancy;
   } queue_status_type;

   class match_queue_scoreboard;
      record_type       held[$];
      queue_status_type expected[$];
      int unsigned      errors;
      int unsigned      sent;
      int unsigned      takes;
      int unsigned      hits;
      int unsigned      drops;
      int unsigned      peak;

      function void note_request(op_type op, record_type rec);
         queue_status_type st;
         st = '0;
         sent++;
         if (op == OP_INSERT) begin
            if (held.size() >= DEPTH) begin
               void'(held.pop_front());
               st.dropped_oldest = 1'b1;
               drops++;
            end
            held.push_back(rec);
         end else begin
            takes++;
            foreach (held[i]) begin
               if (held[i] == rec) begin
                  held.delete(i);
                  st.matched = 1'b1;
                  hits++;
                  break;
               end
            end
         end
         st.occupancy = 7'(held.size());
         if (held.size() > peak) peak = held.size();
         expected.push_back(st);
      endfunction

      function void check_response(logic matched, logic dropped_oldest, logic [6:0] occupancy);
         queue_status_type st;
         if (expected.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         st = expected.pop_front();
         if (matched !== st.matched) begin
            $error("matched: expected %0d, actual %0d", st.matched, matched);
            errors++;
         end
         if (dropped_oldest !== st.dropped_oldest) begin
            $error("dropped_oldest: expected %0d, actual %0d", st.dropped_oldest,
                   dropped_oldest);
            errors++;
         end
         if (occupancy !== st.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", st.occupancy, occupancy);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   bit          idle_enable;
   bit          hold_request;
   int unsigned cycle_count;

   match_queue_scoreboard sb;

   omrq_req_if req_chan ();
   omrq_rsp_if rsp_chan ();

   ordered_match_remove_queue #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("ordered_match_remove_queue: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_response(rsp_chan.matched, rsp_chan.dropped_oldest, rsp_chan.occupancy);
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_chan.ready <= !(idle_enable && $urandom_range(99, 0) < 9);
      end
   end

   function automatic record_type random_record();
      record_type rec;
      rec.event_kind    = 1'($urandom);
      rec.event_time    = $urandom;
      rec.window_number = $urandom;
      rec.scan_code     = 9'($urandom);
      rec.key_symbol    = 31'($urandom);
      return rec;
   endfunction

   function automatic record_type flip_one_bit(record_type rec);
      logic [$bits(record_type)-1:0] mask;
      mask = '0;
      mask[$urandom_range($bits(record_type) - 1, 0)] = 1'b1;
      return record_type'(rec ^ mask);
   endfunction

   task automatic send_item(input op_type op, input record_type rec);
      while (idle_enable && $urandom_range(99, 0) < 9) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.op            <= op;
      req_chan.event_kind    <= rec.event_kind;
      req_chan.event_time    <= rec.event_time;
      req_chan.window_number <= rec.window_number;
      req_chan.scan_code     <= rec.scan_code;
      req_chan.key_symbol    <= rec.key_symbol;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, rec);
      @(negedge clock);
   endtask

   initial begin
      record_type       zeros;
      record_type       ones;
      record_type       other;
      record_type       rec;
      traffic_mode_type mode;
      int unsigned      insert_pct;
      int unsigned      pick;

      sb = new;
      idle_enable            = 1'b1;
      hold_request           = 1'b0;
      cycle_count            = 0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.op            = OP_INSERT;
      req_chan.event_kind    = 1'b0;
      req_chan.event_time    = '0;
      req_chan.window_number = '0;
      req_chan.scan_code     = '0;
      req_chan.key_symbol    = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty take, field extremes, near misses, duplicates
      zeros = '0;
      ones  = '1;
      other = random_record();
      send_item(OP_TAKE, zeros);
      send_item(OP_INSERT, zeros);
      send_item(OP_INSERT, ones);
      send_item(OP_INSERT, zeros);
      send_item(OP_INSERT, other);
      send_item(OP_TAKE, flip_one_bit(ones));
      send_item(OP_TAKE, flip_one_bit(zeros));
      send_item(OP_TAKE, ones);
      send_item(OP_TAKE, zeros);
      send_item(OP_TAKE, zeros);
      send_item(OP_TAKE, zeros);
      send_item(OP_TAKE, other);
      send_item(OP_TAKE, other);
      send_item(OP_INSERT, ones);
      send_item(OP_TAKE, ones);

      mode       = MODE_FILL;
      insert_pct = 90;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 0) hold_request = 1'b1;
         if (n > 0 && n % SEGMENT_LEN == 0) begin
            mode = traffic_mode_type'($urandom_range(2, 0));
            case (mode)
               MODE_FILL:  insert_pct = 85;
               MODE_DRAIN: insert_pct = 15;
               default:    insert_pct = 50;
            endcase
         end
         idle_enable = !(n >= 500 && n < 700);
         pick = $urandom_range(99, 0);
         if ($urandom_range(99, 0) < insert_pct) begin
            if (pick < 55 || sb.held.size() == 0) begin
               rec = random_record();
            end else if (pick < 75) begin
               rec = sb.held[$urandom_range(sb.held.size() - 1, 0)];
            end else begin
               rec.event_kind    = 1'($urandom);
               rec.event_time    = 32'($urandom_range(3, 0));
               rec.window_number = 32'($urandom_range(1, 0));
               rec.scan_code     = 9'($urandom_range(2, 0));
               rec.key_symbol    = 31'($urandom_range(1, 0));
            end
            send_item(OP_INSERT, rec);
         end else begin
            if (sb.held.size() == 0 || pick >= 85) begin
               rec = random_record();
            end else begin
               rec = sb.held[$urandom_range(sb.held.size() - 1, 0)];
               if (pick >= 65) rec = flip_one_bit(rec);
            end
            send_item(OP_TAKE, rec);
         end
      end
      req_chan.valid <= 1'b0;

      while (sb.expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d transactions: %0d takes with %0d hits, %0d oldest-record drops",
               sb.sent, sb.takes, sb.hits, sb.drops);
      $display("peak fill %0d of %0d, %0d cycles", sb.peak, DEPTH, cycle_count);
      if (sb.errors == 0) begin
         $display("ordered_match_remove_queue: match");
      end else begin
         $display("ordered_match_remove_queue: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/omrq_pkg.sv
rtl/omrq_req_if.sv
rtl/omrq_rsp_if.sv
rtl/omrq_cell.sv
rtl/ordered_match_remove_queue.sv
sim/tb_top.sv
